### design/pwd_pkg.sv
// Package for the windowed-derivative PID regulator.
// Holds the field widths, fixed-point constants and command codes.
// No dependencies; used by pid_windowed_derivative, pwd_checker and the testbench.
package pwd_pkg;

  // payload and register widths
  localparam int MEAS_W   = 16;   // measured, signed Q11.4
  localparam int TGT_W    = 12;   // target / setpoint, signed whole degrees
  localparam int GAIN_W   = 16;   // gains, signed Q8.8
  localparam int DRIVE_W  = 32;   // drive result
  localparam int CFG_IDX_W = 2;

  // internal arithmetic widths
  localparam int FRAC_Q4  = 4;                    // Q.4 of errors
  localparam int ERR_W    = 18;                   // error, Q.4
  localparam int SUM_W    = 14;                   // clamped integral, Q.4
  localparam int ACC_W    = 19;                   // integral before clamping
  localparam int DELTA_W  = 19;                   // one error difference
  localparam int DTOT_W   = 21;                   // windowed delta sum
  localparam int P_PROP_W = ERR_W + GAIN_W;       // 34
  localparam int P_INTG_W = SUM_W + GAIN_W;       // 30
  localparam int P_DERV_W = DTOT_W + GAIN_W;      // 37
  localparam int TOT_W    = P_DERV_W + 2;         // 39
  localparam int FRAC_OUT = 12;                   // Q.12 of the product sum
  localparam int WHOLE_W  = TOT_W - FRAC_OUT;     // 27
  localparam int SAT_W    = 40;                   // room for the doubled value

  localparam int INTEG_LIMIT = 256 * 16;          // +-256 degrees in Q.4
  localparam int RESET_STEP  = 10;                // whole degrees

  localparam logic signed [SAT_W-1:0] DRIVE_HI = 40'sh00_7FFF_FFFE;
  localparam logic signed [SAT_W-1:0] DRIVE_LO = 40'shFF_8000_0000;

  localparam int HISTORY_DEPTH_DEF = 4;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TARGET = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2
  } reg_idx_t;

endpackage

### design/pid_windowed_derivative.sv
// PID regulator with clamped integral and windowed derivative: top level.
// Four-stage pipeline: input register, error/state update, products, result.
// Depends on pwd_pkg.
//
// Usage
//   Sample channel (sample_valid / sample_stall): one beat carries command,
//   measured and target. command CMD_SAMPLE processes a measured value in
//   signed Q11.4 degrees and yields one drive beat; command CMD_TARGET loads
//   a new setpoint and yields nothing. A setpoint step of more than ten
//   degrees clears the integral, the previous error and the delta history.
//   Result channel (result_valid / result_stall): one beat carries drive.
//   Configuration: cfg_write_en with cfg_index / cfg_data writes the
//   proportional, integral or derivative gain (signed Q8.8); write only
//   while no beat is in flight. Other indexes are ignored.
// Timing
//   A sample beat accepted into the input register passes through the
//   operand register (error and history update), the product register (the
//   three gain multiplies), then the truncate/double/saturate into the
//   result register.
//   One beat a cycle is taken in steady flow while the result side is not
//   stalled; the next beat's state update sees the previous one's state.
// Reset and stall
//   rst clears gains, setpoint, integral, history and all stage valids.
//   A stalled result holds; earlier stages keep filling bubbles, and the
//   sample side stalls only once every stage holds a beat.
module pid_windowed_derivative #(
  parameter int HISTORY_DEPTH = pwd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic                                command,
  input  logic signed [pwd_pkg::MEAS_W-1:0]   measured,
  input  logic signed [pwd_pkg::TGT_W-1:0]    target,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [pwd_pkg::DRIVE_W-1:0]  drive,
  // configuration write port
  input  logic                                cfg_write_en,
  input  logic [pwd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pwd_pkg::GAIN_W-1:0]          cfg_data
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

  // ---------------------------------------------------------------- gains
  logic signed [pwd_pkg::GAIN_W-1:0] prop_gain, integ_gain, deriv_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        pwd_pkg::REG_PROP_GAIN:  prop_gain  <= cfg_data;
        pwd_pkg::REG_INTEG_GAIN: integ_gain <= cfg_data;
        pwd_pkg::REG_DERIV_GAIN: deriv_gain <= cfg_data;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------- stage ready
  logic s0_valid, s1_valid, s2_valid;
  logic s0_ready, s1_ready, s2_ready, s3_ready;

  // each stage takes a beat when it is empty or its beat moves on
  assign s3_ready     = !result_valid || !result_stall;
  assign s2_ready     = !s2_valid || s3_ready;
  assign s1_ready     = !s1_valid || s2_ready;
  assign s0_ready     = !s0_valid || s1_ready;
  assign sample_stall = !s0_ready;

  // ------------------------------------------------------- input register
  pwd_pkg::cmd_t                      s0_cmd;
  logic signed [pwd_pkg::MEAS_W-1:0]  s0_meas;
  logic signed [pwd_pkg::TGT_W-1:0]   s0_tgt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && sample_valid) begin
      s0_cmd  <= pwd_pkg::cmd_t'(command);
      s0_meas <= measured;
      s0_tgt  <= target;
    end
  end

  // ---------------------------------------------------- regulator state
  logic signed [pwd_pkg::TGT_W-1:0]   setpoint;
  logic signed [pwd_pkg::SUM_W-1:0]   error_sum;
  logic signed [pwd_pkg::ERR_W-1:0]   previous_error;
  logic signed [pwd_pkg::DELTA_W-1:0] delta_ring [HISTORY_DEPTH];
  logic signed [pwd_pkg::DTOT_W-1:0]  delta_total;
  logic [PTR_W-1:0]                   ring_pointer;

  logic                               s0_fire;
  logic signed [pwd_pkg::ERR_W-1:0]   err;
  logic signed [pwd_pkg::ACC_W-1:0]   acc_raw;
  logic signed [pwd_pkg::SUM_W-1:0]   error_sum_next;
  logic signed [pwd_pkg::DELTA_W-1:0] delta;
  logic signed [pwd_pkg::DTOT_W-1:0]  delta_total_next;
  logic [PTR_W-1:0]                   ring_pointer_next;
  logic signed [pwd_pkg::TGT_W:0]     step;
  logic                               big_step;

  assign s0_fire = s0_valid && s1_ready;

  always_comb begin
    // error in Q.4: setpoint scaled by 16 minus the measured value
    err = (pwd_pkg::ERR_W'(setpoint) <<< pwd_pkg::FRAC_Q4) - pwd_pkg::ERR_W'(s0_meas);

    // integral, clamped to +-256 degrees
    acc_raw = pwd_pkg::ACC_W'(error_sum) + pwd_pkg::ACC_W'(err);
    if (acc_raw > pwd_pkg::ACC_W'(pwd_pkg::INTEG_LIMIT)) begin
      error_sum_next = pwd_pkg::SUM_W'(pwd_pkg::INTEG_LIMIT);
    end else if (acc_raw < -pwd_pkg::ACC_W'(pwd_pkg::INTEG_LIMIT)) begin
      error_sum_next = -pwd_pkg::SUM_W'(pwd_pkg::INTEG_LIMIT);
    end else begin
      error_sum_next = pwd_pkg::SUM_W'(acc_raw);
    end

    // windowed derivative: drop the oldest delta, add the newest
    delta = pwd_pkg::DELTA_W'(err) - pwd_pkg::DELTA_W'(previous_error);
    delta_total_next = delta_total - pwd_pkg::DTOT_W'(delta_ring[ring_pointer])
                     + pwd_pkg::DTOT_W'(delta);
    ring_pointer_next = (ring_pointer == PTR_LAST) ? '0 : ring_pointer + PTR_W'(1);

    // setpoint step size in whole degrees
    step     = (pwd_pkg::TGT_W+1)'(setpoint) - (pwd_pkg::TGT_W+1)'(s0_tgt);
    big_step = (step > (pwd_pkg::TGT_W+1)'(pwd_pkg::RESET_STEP))
            || (step < -(pwd_pkg::TGT_W+1)'(pwd_pkg::RESET_STEP));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= '0;
      error_sum      <= '0;
      previous_error <= '0;
      delta_total    <= '0;
      ring_pointer   <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        delta_ring[i] <= '0;
      end
    end else if (s0_fire) begin
      case (s0_cmd)
        pwd_pkg::CMD_TARGET: begin
          // large step: drop integral and derivative history
          if (big_step) begin
            error_sum      <= '0;
            previous_error <= '0;
            delta_total    <= '0;
            ring_pointer   <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
              delta_ring[i] <= '0;
            end
          end
          setpoint <= s0_tgt;
        end
        default: begin
          error_sum                  <= error_sum_next;
          previous_error             <= err;
          delta_ring[ring_pointer]   <= delta;
          delta_total                <= delta_total_next;
          ring_pointer               <= ring_pointer_next;
        end
      endcase
    end
  end

  // ------------------------------------------------- stage 1: operands
  logic signed [pwd_pkg::ERR_W-1:0]  s1_err;
  logic signed [pwd_pkg::SUM_W-1:0]  s1_sum;
  logic signed [pwd_pkg::DTOT_W-1:0] s1_dtot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      // target beats end here
      s1_valid <= s0_valid && (s0_cmd == pwd_pkg::CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      s1_err  <= err;
      s1_sum  <= error_sum_next;
      s1_dtot <= delta_total_next;
    end
  end

  // ------------------------------------------------- stage 2: products
  logic signed [pwd_pkg::P_PROP_W-1:0] s2_prop;
  logic signed [pwd_pkg::P_INTG_W-1:0] s2_intg;
  logic signed [pwd_pkg::P_DERV_W-1:0] s2_derv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_prop <= pwd_pkg::P_PROP_W'(s1_err)  * pwd_pkg::P_PROP_W'(prop_gain);
      s2_intg <= pwd_pkg::P_INTG_W'(s1_sum)  * pwd_pkg::P_INTG_W'(integ_gain);
      s2_derv <= pwd_pkg::P_DERV_W'(s1_dtot) * pwd_pkg::P_DERV_W'(deriv_gain);
    end
  end

  // ------------------------------------ stage 3: truncate, double, clamp
  logic signed [pwd_pkg::TOT_W-1:0]   total;
  logic signed [pwd_pkg::WHOLE_W-1:0] whole;
  logic signed [pwd_pkg::SAT_W-1:0]   doubled;
  logic signed [pwd_pkg::DRIVE_W-1:0] drive_next;

  always_comb begin
    total = pwd_pkg::TOT_W'(s2_prop) + pwd_pkg::TOT_W'(s2_intg)
          + pwd_pkg::TOT_W'(s2_derv);
    // truncate toward zero: a negative value with a fraction rounds up
    whole = total[pwd_pkg::TOT_W-1:pwd_pkg::FRAC_OUT];
    if (total[pwd_pkg::TOT_W-1] && (|total[pwd_pkg::FRAC_OUT-1:0])) begin
      whole = whole + pwd_pkg::WHOLE_W'(1);
    end
    doubled = pwd_pkg::SAT_W'(whole) <<< 1;
    if (doubled > pwd_pkg::DRIVE_HI) begin
      drive_next = pwd_pkg::DRIVE_W'(pwd_pkg::DRIVE_HI);
    end else if (doubled < pwd_pkg::DRIVE_LO) begin
      drive_next = pwd_pkg::DRIVE_W'(pwd_pkg::DRIVE_LO);
    end else begin
      drive_next = pwd_pkg::DRIVE_W'(doubled);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s3_ready) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      drive <= drive_next;
    end
  end

endmodule

### design/pwd_checker.sv
// Port-level checker for pid_windowed_derivative, with its bind.
// Watches the sample and result channels only. Depends on pwd_pkg.
module pwd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_valid,
  input logic                                sample_stall,
  input logic                                command,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic signed [pwd_pkg::DRIVE_W-1:0]  drive
);

  logic sample_beat;
  assign sample_beat = sample_valid && !sample_stall
                    && (command == pwd_pkg::CMD_SAMPLE);

  // reset empties the result stage
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set after reset");

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(drive))
    else $error("stalled result beat changed");

  // the sample side only stalls behind a stalled, waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("sample stalled without a held result");

  // with the result side flowing, a sample beat moves through the pipe
  // and reaches the result register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    sample_beat ##1 !result_stall ##1 !result_stall ##1 !result_stall
    |=> result_valid)
    else $error("sample beat produced no result in time");

endmodule

bind pid_windowed_derivative pwd_checker u_pwd_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .command      (command),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .drive        (drive)
);

### tb/tb_pid_windowed_derivative.sv
// Self-checking testbench for the windowed-derivative PID regulator.
// Holds the clock, reset, beat driver, result monitor and a built-in drive predictor.
// Depends on pwd_pkg and pid_windowed_derivative.
module tb_pid_windowed_derivative;

  localparam int RING_DEPTH   = pwd_pkg::HISTORY_DEPTH_DEF;
  localparam int DRAIN_CYCLES = 8;       // room for the pipeline to drain
  localparam int PHASE_BEATS  = 250;
  localparam int HOLD_CYCLES  = 200;
  localparam logic [pwd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int Q12_DIV = 1 << pwd_pkg::FRAC_OUT;
  localparam int SCALE   = 2;

  typedef struct {
    pwd_pkg::cmd_t                     cmd;
    logic signed [pwd_pkg::MEAS_W-1:0] meas;
    logic signed [pwd_pkg::TGT_W-1:0]  tgt;
  } sample_beat_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                sample_valid = 1'b0;
  logic                                sample_stall;
  logic                                command = pwd_pkg::CMD_SAMPLE;
  logic signed [pwd_pkg::MEAS_W-1:0]   measured = '0;
  logic signed [pwd_pkg::TGT_W-1:0]    target = '0;
  logic                                result_valid;
  logic                                result_stall = 1'b0;
  logic signed [pwd_pkg::DRIVE_W-1:0]  drive;
  logic                                cfg_write_en = 1'b0;
  logic [pwd_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [pwd_pkg::GAIN_W-1:0]          cfg_data = '0;

  pid_windowed_derivative DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .command      (command),
    .measured     (measured),
    .target       (target),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .drive        (drive),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus plumbing shared between the sequencer and the driver processes
  sample_beat_t                       beats_pending[$];
  logic signed [pwd_pkg::DRIVE_W-1:0] drive_expected[$];
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_token     = 0;
  int  fail_count     = 0;
  logic in_beat_taken = 1'b0;
  int  plan_setpoint  = 0;   // setpoint as the sequencer sees it, for near-target values

  // Predictor state: gains, setpoint, integral and delta history
  logic signed [pwd_pkg::GAIN_W-1:0]  kp_gain, ki_gain, kd_gain;
  logic signed [pwd_pkg::TGT_W-1:0]   sp_deg;
  logic signed [pwd_pkg::SUM_W-1:0]   integ_q4;
  logic signed [pwd_pkg::ERR_W-1:0]   last_err;
  logic signed [pwd_pkg::DELTA_W-1:0] delta_hist[RING_DEPTH];
  logic signed [pwd_pkg::DTOT_W-1:0]  delta_total;
  int                                 ring_ptr;

  task automatic clear_history();
    integ_q4    = '0;
    last_err    = '0;
    delta_total = '0;
    ring_ptr    = 0;
    for (int i = 0; i < RING_DEPTH; i++) delta_hist[i] = '0;
  endtask

  // Advance the predictor by one accepted beat; report whether a drive beat follows
  task automatic regulate_beat(input sample_beat_t b, output bit has_drive,
                               output logic signed [pwd_pkg::DRIVE_W-1:0] drv);
    longint err, acc, delta, prod_sum, whole, dbl, step;
    has_drive = 1'b0;
    drv       = '0;
    if (b.cmd == pwd_pkg::CMD_TARGET) begin
      step = longint'(sp_deg) - longint'(b.tgt);
      if (step < 0) step = -step;
      // a setpoint jump beyond the step threshold wipes the history, gains stay
      if (step > pwd_pkg::RESET_STEP) clear_history();
      sp_deg = b.tgt;
    end else begin
      err = longint'(sp_deg) * 16 - longint'(b.meas);
      acc = longint'(integ_q4) + err;
      if (acc > pwd_pkg::INTEG_LIMIT) acc = pwd_pkg::INTEG_LIMIT;
      else if (acc < -pwd_pkg::INTEG_LIMIT) acc = -pwd_pkg::INTEG_LIMIT;
      integ_q4 = pwd_pkg::SUM_W'(acc);
      delta = err - longint'(last_err);
      delta_total = pwd_pkg::DTOT_W'(longint'(delta_total)
                  - longint'(delta_hist[ring_ptr]) + delta);
      delta_hist[ring_ptr] = pwd_pkg::DELTA_W'(delta);
      ring_ptr = (ring_ptr + 1) % RING_DEPTH;
      last_err = pwd_pkg::ERR_W'(err);
      prod_sum = err * longint'(kp_gain) + acc * longint'(ki_gain)
               + longint'(delta_total) * longint'(kd_gain);
      whole = prod_sum / Q12_DIV;   // signed division truncates toward zero
      dbl   = whole * SCALE;
      if (dbl > longint'(pwd_pkg::DRIVE_HI)) dbl = longint'(pwd_pkg::DRIVE_HI);
      else if (dbl < longint'(pwd_pkg::DRIVE_LO)) dbl = longint'(pwd_pkg::DRIVE_LO);
      drv       = pwd_pkg::DRIVE_W'(dbl);
      has_drive = 1'b1;
    end
  endtask

  // Sample-side driver: hold a stalled beat, otherwise offer the next one or idle
  always @(negedge clk) begin
    sample_beat_t nxt;
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || in_beat_taken) begin
      if (beats_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = beats_pending.pop_front();
        sample_valid <= 1'b1;
        command      <= nxt.cmd;
        measured     <= nxt.meas;
        target       <= nxt.tgt;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Result-side stall: a requested hold-off wins, else random per the phase
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: track gain writes, predict on accepted sample beats, check drive beats
  always @(posedge clk) begin
    sample_beat_t                       acc_beat;
    bit                                 has_drive;
    logic signed [pwd_pkg::DRIVE_W-1:0] want;
    logic signed [pwd_pkg::DRIVE_W-1:0] drv;
    if (rst) begin
      kp_gain = '0;
      ki_gain = '0;
      kd_gain = '0;
      sp_deg  = '0;
      clear_history();
      drive_expected.delete();
      in_beat_taken <= 1'b0;
    end else begin
      in_beat_taken <= sample_valid && !sample_stall;
      if (cfg_write_en) begin
        case (cfg_index)
          pwd_pkg::REG_PROP_GAIN:  kp_gain = cfg_data;
          pwd_pkg::REG_INTEG_GAIN: ki_gain = cfg_data;
          pwd_pkg::REG_DERIV_GAIN: kd_gain = cfg_data;
          default: ;   // unused index: drop the write
        endcase
      end
      // check before predicting: a drive beat always belongs to an older sample
      if (result_valid && !result_stall) begin
        if (drive_expected.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: drive beat %0d arrived with none outstanding", $time, drive);
          fail_count++;
        end else begin
          want = drive_expected.pop_front();
          if (drive !== want) begin
            if (fail_count < 10)
              $display("%0t: drive mismatch, expected %0d got %0d", $time, want, drive);
            fail_count++;
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        acc_beat.cmd  = pwd_pkg::cmd_t'(command);
        acc_beat.meas = measured;
        acc_beat.tgt  = target;
        regulate_beat(acc_beat, has_drive, drv);
        if (has_drive) drive_expected.push_back(drv);
      end
    end
  end

  task automatic write_reg(input logic [pwd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pwd_pkg::GAIN_W-1:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic set_gains(input logic [pwd_pkg::GAIN_W-1:0] kp,
                           input logic [pwd_pkg::GAIN_W-1:0] ki,
                           input logic [pwd_pkg::GAIN_W-1:0] kd);
    write_reg(pwd_pkg::REG_PROP_GAIN, kp);
    write_reg(pwd_pkg::REG_INTEG_GAIN, ki);
    write_reg(pwd_pkg::REG_DERIV_GAIN, kd);
  endtask

  // Unused payload fields carry random bits so every input bit toggles
  task automatic push_sample(input int meas);
    sample_beat_t b;
    b.cmd  = pwd_pkg::CMD_SAMPLE;
    b.meas = pwd_pkg::MEAS_W'(meas);
    b.tgt  = pwd_pkg::TGT_W'($urandom);
    beats_pending.push_back(b);
  endtask

  task automatic push_target(input int tgt);
    sample_beat_t b;
    b.cmd  = pwd_pkg::CMD_TARGET;
    b.meas = pwd_pkg::MEAS_W'($urandom);
    b.tgt  = pwd_pkg::TGT_W'(tgt);
    plan_setpoint = int'(b.tgt);
    beats_pending.push_back(b);
  endtask

  // Mostly samples near the setpoint, some wild values, some small and large target steps
  task automatic push_random(input int count);
    int r, v;
    for (int i = 0; i < count; i++) begin
      r = int'($urandom_range(0, 99));
      if (r < 7) begin
        v = plan_setpoint + int'($urandom_range(0, 24)) - 12;
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        push_target(v);
      end else if (r < 12) begin
        push_target($signed(12'($urandom)));
      end else if (r < 82) begin
        v = plan_setpoint * 16 + int'($urandom_range(0, 2047)) - 1024;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        push_sample(v);
      end else begin
        push_sample($signed(16'($urandom)));
      end
    end
  endtask

  // Wait for the pipe to empty, then let any trailing target beat settle
  task automatic wait_idle();
    do @(posedge clk);
    while (beats_pending.size() != 0 || sample_valid || drive_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, clamping both ways, step exactly at and just past the
    // threshold, an unchanged target, and enough samples to wrap the delta ring
    set_gains(16'sh0100, 16'sh0040, 16'sh0200);
    push_sample(0);
    push_sample(32767);
    push_sample(-32768);
    push_sample(1);
    push_sample(-1);
    push_target(2047);
    push_sample(-32768);
    push_sample(-32768);
    push_sample(32767);
    push_target(-2048);
    push_sample(32767);
    push_sample(32767);
    push_target(-2038);
    push_sample(-32608);
    push_target(-2027);
    push_target(-2027);
    push_sample(-32427);
    push_sample(-32332);
    push_sample(-32532);
    push_sample(-32232);
    push_sample(-32432);
    push_sample(-32382);
    push_target(0);
    push_sample(-32768);
    push_sample(4096);
    wait_idle();

    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_gains(16'($urandom), 16'($urandom), 16'($urandom));
        end
        2: begin
          send_idle_pct = 86; recv_stall_pct = 0;
          set_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        end
        3: begin
          send_idle_pct = 0;  recv_stall_pct = 86;
          set_gains(16'sh8000, 16'sh8000, 16'sh8000);
        end
        4: begin
          send_idle_pct = 32; recv_stall_pct = 32;
          set_gains(16'sh7FFF, 16'sh8000, 16'sh0000);
        end
        5: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_gains(16'($urandom), 16'($urandom), 16'($urandom));
        end
        6: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_gains(16'sh0000, 16'sh7FFF, 16'sh8000);
          write_reg(REG_UNUSED, 16'($urandom));
        end
        default: begin
          send_idle_pct = 32; recv_stall_pct = 32;
          set_gains(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                    16'($urandom_range(0, 2047) - 1024));
        end
      endcase
      if (ph == 5) begin
        // Hold off the result side for a long stretch while beats keep coming,
        // then pause the sender until the pipe has drained before the rest
        hold_token = hold_token + 1;
        push_random(PHASE_BEATS / 2);
        wait_idle();
        push_random(PHASE_BEATS - PHASE_BEATS / 2);
      end else begin
        push_random(PHASE_BEATS);
      end
      wait_idle();
    end

    if (drive_expected.size() != 0) begin
      $display("%0d drive beats never arrived", drive_expected.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(20 * 200000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
